/* rtl/isms_pkg.sv */
// ----------------------------------------------------------------------------
// isms_pkg - interval sort/merge shared definitions
// Types, constants and state codes for the range sort and merge block.
// ----------------------------------------------------------------------------
package isms_pkg;

  localparam int unsigned MaxRanges = 32;
  localparam int unsigned AddrBits  = 64;
  localparam int unsigned DropBits  = 8;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [DropBits-1:0] drop_t;

  typedef struct packed {
    addr_t start;
    addr_t stop;
  } slot_t;

  // operands for the shared comparator: lt/eq on pair a, lt on pair b
  typedef struct packed {
    addr_t a0;
    addr_t b0;
    addr_t a1;
    addr_t b1;
  } cmp_ops_t;

  typedef struct packed {
    logic lt_a;
    logic eq_a;
    logic lt_b;
  } cmp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS,
    S_INS_PUT,
    S_MRG_START,
    S_MRG_LOAD,
    S_MRG_STEP,
    S_MRG_TAIL
  } isms_state_e;

endpackage

/* rtl/isms_if.sv */
// ----------------------------------------------------------------------------
// isms_if - item channels
// Valid/ready channels for incoming ranges and outgoing merged ranges.
// ----------------------------------------------------------------------------
interface isms_in_if;
  logic            valid;
  logic            ready;
  isms_pkg::addr_t range_start;
  isms_pkg::addr_t range_end;
  logic            is_final;

  modport source (output valid, output range_start, output range_end,
                  output is_final, input ready);
  modport sink   (input valid, input range_start, input range_end,
                  input is_final, output ready);
endinterface

interface isms_out_if;
  logic            valid;
  logic            ready;
  isms_pkg::addr_t merged_start;
  isms_pkg::addr_t merged_end;
  logic            set_empty;
  logic            run_last;
  isms_pkg::drop_t dropped_count;

  modport source (output valid, output merged_start, output merged_end,
                  output set_empty, output run_last, output dropped_count,
                  input ready);
  modport sink   (input valid, input merged_start, input merged_end,
                  input set_empty, input run_last, input dropped_count,
                  output ready);
endinterface

/* rtl/isms_store.sv */
// ----------------------------------------------------------------------------
// isms_store - range store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isms_store #(
  parameter int unsigned Depth = isms_pkg::MaxRanges,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  isms_pkg::slot_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output isms_pkg::slot_t     rdata_o
);

  isms_pkg::slot_t mem_q [Depth];
  isms_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/isms_cmp.sv */
// ----------------------------------------------------------------------------
// isms_cmp - shared comparator
// Unsigned less-than and equality on pair a, less-than on pair b.
// ----------------------------------------------------------------------------
module isms_cmp (
  input  isms_pkg::cmp_ops_t ops_i,
  output isms_pkg::cmp_res_t res_o
);

  assign res_o.lt_a = ops_i.a0 <  ops_i.b0;
  assign res_o.eq_a = ops_i.a0 == ops_i.b0;
  assign res_o.lt_b = ops_i.a1 <  ops_i.b1;

endmodule

/* rtl/interval_sort_merge_unit.sv */
// ----------------------------------------------------------------------------
// interval_sort_merge_unit - sorted range store with merge on final item
// Operation: a non-final item is checked and ends there if dropped or the
//   store is empty; else ranges sorting after it shift up and it is inserted.
// A final item then walks the store, held by output stalls; an empty set gives
//   a single set_empty item. Ready is low throughout.
// Reset: control, count and drop tally clear; store contents are not cleared.
// ----------------------------------------------------------------------------
module interval_sort_merge_unit #(
  parameter int unsigned MAX_RANGES = isms_pkg::MaxRanges
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  isms_in_if.sink    rng_i,
  isms_out_if.source mrg_o
);

  localparam int unsigned AddrW = $clog2(MAX_RANGES);
  localparam int unsigned CntW  = $clog2(MAX_RANGES + 1);

  isms_pkg::isms_state_e state_q, state_d;
  isms_pkg::addr_t       s_q, e_q;
  logic                  fin_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  isms_pkg::drop_t       tally_q, tally_d;
  logic [AddrW-1:0]      idx_q, idx_d;
  isms_pkg::addr_t       cs_q, cs_d, ce_q, ce_d;

  logic                  ov_q, ov_d;
  isms_pkg::addr_t       ostart_q, ostart_d, oend_q, oend_d;
  logic                  oempty_q, oempty_d, olast_q, olast_d;
  isms_pkg::drop_t       odrop_q, odrop_d;

  logic                  we;
  logic [AddrW-1:0]      waddr, raddr;
  isms_pkg::slot_t       wdata, rdata, new_slot;
  isms_pkg::cmp_ops_t    ops;
  isms_pkg::cmp_res_t    res;

  logic [CntW-1:0]       cnt_m1;
  logic [AddrW-1:0]      last_idx, idx_p1, idx_m1;
  logic                  full, out_free, out_load, sorts_first;
  isms_pkg::isms_state_e done_state;

  isms_store #(.Depth(MAX_RANGES)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  isms_cmp u_cmp (
    .ops_i (ops),
    .res_o (res)
  );

  assign cnt_m1         = cnt_q - 1'b1;
  assign last_idx       = cnt_m1[AddrW-1:0];
  assign idx_p1         = idx_q + 1'b1;
  assign idx_m1         = idx_q - 1'b1;
  assign full           = cnt_q == CntW'(MAX_RANGES);
  assign out_free       = !ov_q || mrg_o.ready;
  assign new_slot.start = s_q;
  assign new_slot.stop  = e_q;
  assign sorts_first    = res.lt_a || (res.eq_a && res.lt_b);
  assign done_state     = fin_q ? isms_pkg::S_MRG_START : isms_pkg::S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isms_pkg::S_IDLE;
      cnt_q   <= '0;
      tally_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tally_q <= tally_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rng_i.valid && rng_i.ready) begin
      s_q   <= rng_i.range_start;
      e_q   <= rng_i.range_end;
      fin_q <= rng_i.is_final;
    end
    idx_q    <= idx_d;
    cs_q     <= cs_d;
    ce_q     <= ce_d;
    ostart_q <= ostart_d;
    oend_q   <= oend_d;
    oempty_q <= oempty_d;
    olast_q  <= olast_d;
    odrop_q  <= odrop_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    tally_d  = tally_q;
    idx_d    = idx_q;
    cs_d     = cs_q;
    ce_d     = ce_q;
    we       = 1'b0;
    waddr    = idx_p1;
    wdata    = new_slot;
    raddr    = idx_q;
    ops      = '0;
    out_load = 1'b0;
    ostart_d = ostart_q;
    oend_d   = oend_q;
    oempty_d = oempty_q;
    olast_d  = olast_q;
    odrop_d  = odrop_q;

    unique case (state_q)
      isms_pkg::S_IDLE: begin
        if (rng_i.valid) begin
          state_d = isms_pkg::S_CHECK;
        end
      end
      isms_pkg::S_CHECK: begin
        ops.a0 = s_q;
        ops.b0 = e_q;
        if (!res.lt_a || full) begin
          if (tally_q != '1) begin
            tally_d = tally_q + 1'b1;
          end
          state_d = done_state;
        end else if (cnt_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          cnt_d   = cnt_q + 1'b1;
          state_d = done_state;
        end else begin
          raddr   = last_idx;
          idx_d   = last_idx;
          state_d = isms_pkg::S_INS;
        end
      end
      isms_pkg::S_INS: begin
        ops.a0 = s_q;
        ops.b0 = rdata.start;
        ops.a1 = e_q;
        ops.b1 = rdata.stop;
        we     = 1'b1;
        if (sorts_first) begin
          wdata = rdata;
          if (idx_q == '0) begin
            state_d = isms_pkg::S_INS_PUT;
          end else begin
            raddr = idx_m1;
            idx_d = idx_m1;
          end
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = done_state;
        end
      end
      isms_pkg::S_INS_PUT: begin
        we      = 1'b1;
        waddr   = '0;
        cnt_d   = cnt_q + 1'b1;
        state_d = done_state;
      end
      isms_pkg::S_MRG_START: begin
        if (cnt_q == '0) begin
          if (out_free) begin
            out_load = 1'b1;
            ostart_d = '0;
            oend_d   = '0;
            oempty_d = 1'b1;
            olast_d  = 1'b1;
            odrop_d  = tally_q;
            tally_d  = '0;
            state_d  = isms_pkg::S_IDLE;
          end
        end else begin
          raddr   = '0;
          idx_d   = '0;
          state_d = isms_pkg::S_MRG_LOAD;
        end
      end
      isms_pkg::S_MRG_LOAD: begin
        cs_d = rdata.start;
        ce_d = rdata.stop;
        if (idx_q == last_idx) begin
          state_d = isms_pkg::S_MRG_TAIL;
        end else begin
          raddr   = idx_p1;
          idx_d   = idx_p1;
          state_d = isms_pkg::S_MRG_STEP;
        end
      end
      isms_pkg::S_MRG_STEP: begin
        ops.a0 = ce_q;
        ops.b0 = rdata.start;
        ops.a1 = ce_q;
        ops.b1 = rdata.stop;
        if (!res.lt_a || out_free) begin
          if (res.lt_a) begin
            out_load = 1'b1;
            ostart_d = cs_q;
            oend_d   = ce_q;
            oempty_d = 1'b0;
            olast_d  = 1'b0;
            odrop_d  = tally_q;
            cs_d     = rdata.start;
            ce_d     = rdata.stop;
          end else if (res.lt_b) begin
            ce_d = rdata.stop;
          end
          if (idx_q == last_idx) begin
            state_d = isms_pkg::S_MRG_TAIL;
          end else begin
            raddr = idx_p1;
            idx_d = idx_p1;
          end
        end
      end
      isms_pkg::S_MRG_TAIL: begin
        if (out_free) begin
          out_load = 1'b1;
          ostart_d = cs_q;
          oend_d   = ce_q;
          oempty_d = 1'b0;
          olast_d  = 1'b1;
          odrop_d  = tally_q;
          cnt_d    = '0;
          tally_d  = '0;
          state_d  = isms_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = isms_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      ov_d = 1'b1;
    end else if (mrg_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  assign rng_i.ready         = state_q == isms_pkg::S_IDLE;
  assign mrg_o.valid         = ov_q;
  assign mrg_o.merged_start  = ostart_q;
  assign mrg_o.merged_end    = oend_q;
  assign mrg_o.set_empty     = oempty_q;
  assign mrg_o.run_last      = olast_q;
  assign mrg_o.dropped_count = odrop_q;

endmodule
